// ===== rtl/deq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared sizes, request and status codes, and the controller to datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package deq_pkg;

   // Ring size and derived widths.
   localparam int DEPTH    = 16;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int SUM_W    = CNT_W + 1;

   // Fixed field widths.
   localparam int WORD_W   = 32;
   localparam int REQ_W    = 3;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 5;

   // Request codes.
   typedef enum logic [REQ_W-1:0] {
      REQ_PUSH_FRONT = 3'd0,
      REQ_PUSH_BACK  = 3'd1,
      REQ_POP_FRONT  = 3'd2,
      REQ_POP_BACK   = 3'd3,
      REQ_PEEK_FRONT = 3'd4,
      REQ_PEEK_BACK  = 3'd5
   } req_code_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;       // A request beat is accepted this cycle.
      logic load_read;  // Capture the word read from the ring.
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic needs_read; // The current request reads a ring entry.
   } dp_stat_type;

endpackage : deq_pkg
`default_nettype wire

// ===== rtl/deq_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue channel interfaces
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------

// Request channel: operation code and the word to push.
interface deq_req_if;
   logic                           valid;
   logic                           ready;
   logic [deq_pkg::REQ_W-1:0]      req_type;
   logic signed [deq_pkg::WORD_W-1:0] push_value;

   modport source (output valid, req_type, push_value, input ready);
   modport sink   (input valid, req_type, push_value, output ready);
endinterface : deq_req_if

// Response channel: word read, status, fill count and empty flag.
interface deq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [deq_pkg::WORD_W-1:0] read_value;
   logic [deq_pkg::STATUS_W-1:0]      status;
   logic [deq_pkg::FILL_W-1:0]        fill_count;
   logic                              is_empty;

   modport source (output valid, read_value, status, fill_count, is_empty, input ready);
   modport sink   (input valid, read_value, status, fill_count, is_empty, output ready);
endinterface : deq_rsp_if
`default_nettype wire

// ===== rtl/deq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read address per cycle, read data registered.
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int WIDTH   = 32,
   parameter int ENTRIES = 16
) (
   input  wire logic                       clock,
   input  wire logic                       we,
   input  wire logic [$clog2(ENTRIES)-1:0] addr,
   input  wire logic [WIDTH-1:0]           wdata,
   output logic      [WIDTH-1:0]           rdata
);

   logic [WIDTH-1:0] mem_ff [ENTRIES];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule : deq_ram
`default_nettype wire

// ===== rtl/deq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Sequences one request at a time and owns the response valid flag.
// ----------------------------------------------------------------------------
module deq_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire deq_pkg::dp_stat_type stat,
   output deq_pkg::dp_cmd_type       cmd
);
   import deq_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      take;

   // A beat is taken when idle and the response register is free or draining.
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign take      = req_valid && req_ready;

   assign cmd.take      = take;
   assign cmd.load_read = (state_ff == S_READ);
   assign rsp_valid     = rsp_valid_ff;

   // Next state and response valid.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (stat.needs_read) begin
                  state_in = S_READ;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_READ: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The response register is always empty while a ring read is in flight.
   a_read_rsp_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !rsp_valid_ff)
      else $error("response pending during ring read");

   // A ring read always produces a response beat in the following cycle.
   a_read_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("ring read did not produce a response");

   // A request without a ring read is answered in the next cycle.
   a_direct_rsp: assert property (@(posedge clock) disable iff (reset)
      (take && !stat.needs_read) |=> rsp_valid_ff)
      else $error("direct response missing");

endmodule : deq_ctrl
`default_nettype wire

// ===== rtl/deq_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Ring indices, fill count, the entry RAM and the response registers.
// ----------------------------------------------------------------------------
module deq_dp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire deq_pkg::dp_cmd_type                cmd,
   output deq_pkg::dp_stat_type                    stat,
   input  wire logic [deq_pkg::REQ_W-1:0]          req_code,
   input  wire logic signed [deq_pkg::WORD_W-1:0]  push_value,
   output logic signed [deq_pkg::WORD_W-1:0]       read_value,
   output logic [deq_pkg::STATUS_W-1:0]            status,
   output logic [deq_pkg::FILL_W-1:0]              fill_count,
   output logic                                    is_empty
);
   import deq_pkg::*;

   logic [IDX_W-1:0]  front_ff, front_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0] read_value_ff;
   status_type        status_ff, status_in;
   logic [FILL_W-1:0] fill_ff;
   logic              empty_ff;

   logic [IDX_W-1:0]  front_dec, front_inc, back_free, back_last;
   logic [SUM_W-1:0]  sum_free, sum_last;
   logic              full, empty, needs_read;
   logic              ram_we;
   logic [IDX_W-1:0]  ram_addr;
   logic [WORD_W-1:0] ram_rdata;

   // Ring positions around the front and the back.
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - IDX_W'(1);
   assign front_inc = (front_ff == IDX_W'(DEPTH - 1)) ? '0 : front_ff + IDX_W'(1);
   assign sum_free  = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign sum_last  = sum_free - SUM_W'(1);
   assign back_free = (sum_free >= SUM_W'(DEPTH)) ? IDX_W'(sum_free - SUM_W'(DEPTH))
                                                  : IDX_W'(sum_free);
   assign back_last = (sum_last >= SUM_W'(DEPTH)) ? IDX_W'(sum_last - SUM_W'(DEPTH))
                                                  : IDX_W'(sum_last);

   // Decode the request against the current ring state.
   always_comb begin
      front_in   = front_ff;
      count_in   = count_ff;
      status_in  = ST_OK;
      needs_read = 1'b0;
      ram_we     = 1'b0;
      ram_addr   = front_ff;
      case (req_code_type'(req_code))
         REQ_PUSH_FRONT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               ram_we   = 1'b1;
               ram_addr = front_dec;
               front_in = front_dec;
               count_in = count_ff + CNT_W'(1);
            end
         end
         REQ_PUSH_BACK: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               ram_we   = 1'b1;
               ram_addr = back_free;
               count_in = count_ff + CNT_W'(1);
            end
         end
         REQ_POP_FRONT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               needs_read = 1'b1;
               front_in   = front_inc;
               count_in   = count_ff - CNT_W'(1);
            end
         end
         REQ_POP_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               needs_read = 1'b1;
               ram_addr   = back_last;
               count_in   = count_ff - CNT_W'(1);
            end
         end
         REQ_PEEK_FRONT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               needs_read = 1'b1;
            end
         end
         REQ_PEEK_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               needs_read = 1'b1;
               ram_addr   = back_last;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   assign stat.needs_read = needs_read;

   // Entry storage.
   deq_ram #(
      .WIDTH   (WORD_W),
      .ENTRIES (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we && cmd.take),
      .addr  (ram_addr),
      .wdata (WORD_W'(push_value)),
      .rdata (ram_rdata)
   );

   // Ring indices and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (cmd.take) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   // Response payload: status and count at the accept, the word after the read.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         read_value_ff <= '0;
         status_ff     <= status_in;
         fill_ff       <= FILL_W'(count_in);
         empty_ff      <= (count_in == '0);
      end else if (cmd.load_read) begin
         read_value_ff <= ram_rdata;
      end
   end

   assign read_value = signed'(read_value_ff);
   assign status     = status_ff;
   assign fill_count = fill_ff;
   assign is_empty   = empty_ff;

   // The fill count never exceeds the ring size.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond ring size");

   // A rejected push leaves the ring untouched.
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && status_in == ST_FULL) |=> ($stable(count_ff) && $stable(front_ff)))
      else $error("rejected push changed the ring");

   // A ring read is only requested when words are stored.
   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && needs_read) |-> !empty)
      else $error("ring read on empty queue");

endmodule : deq_dp
`default_nettype wire

// ===== rtl/double_ended_queue_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue unit
// Ring-buffer deque of signed 32-bit words with push, pop and peek at both ends.
// ----------------------------------------------------------------------------
// Each request beat pushes a word at the front or back, pops it from either
// end, or peeks at either end, and returns exactly one response beat with the
// word read, a status (ok, full, empty), the fill count after the request and
// an empty flag. Pushes, rejected requests and unused codes are answered in
// the cycle after the accept; pops and peeks pass through S_READ first, as the
// ring is a single-port RAM with a registered read. One request is in work at
// a time: pushes go one beat per cycle while responses are taken; a pop or
// peek blocks new requests until its read is done. The response register lets
// a new request be accepted in the same cycle that the previous response is
// taken. Entries hold no reset value; only pushed words are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
   input wire logic clock,
   input wire logic reset,
   deq_req_if.sink   req_chan,
   deq_rsp_if.source rsp_chan
);
   import deq_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Sequencer.
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Ring state, storage and response payload.
   deq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_code   (req_chan.req_type),
      .push_value (req_chan.push_value),
      .read_value (rsp_chan.read_value),
      .status     (rsp_chan.status),
      .fill_count (rsp_chan.fill_count),
      .is_empty   (rsp_chan.is_empty)
   );

endmodule : double_ended_queue_unit
`default_nettype wire
